// File: design/top_n_logit_selector_macros.svh
// Assertion macros shared by the checker.
`ifndef TOP_N_LOGIT_SELECTOR_MACROS_SVH
`define TOP_N_LOGIT_SELECTOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TNLS_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);

// Condition that must never hold on a clock edge outside reset.
`define TNLS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/tnls_pkg.sv
package tnls_pkg;
    localparam int DEF_MAX_KEEP = 8;
    localparam int DEF_MAX_EXPERTS = 32;
    localparam int VAL_W = 32;
    localparam int IDX_W = 5;
    localparam int RANK_W = 3;
    localparam int KEEP_W = 4;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd2;

    // IEEE a > b; false when either is NaN, signed zeros equal.
    function automatic logic fp_gt(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (a_nan || b_nan || both_zero)
        begin
            res = 1'b0;
        end
        else if (a[31] != b[31])
        begin
            res = !a[31];
        end
        else if (!a[31])
        begin
            res = a[30:0] > b[30:0];
        end
        else
        begin
            res = a[30:0] < b[30:0];
        end
        return res;
    endfunction
endpackage

// File: design/top_n_logit_selector.sv
// Order: a request is captured in the input register and enters the keep list in the
// cycle after acceptance; the report of a final request starts after it has passed the
// input register and the list's rep_load register. Rate: one request per cycle; after a
// final request input is held off until its report has drained (longer under stall).
// Reset: rst_n async active low clears list fill, arrival count, report, keep_count=2.
module top_n_logit_selector import tnls_pkg::*; #(
    parameter int MAX_KEEP = DEF_MAX_KEEP,
    parameter int MAX_EXPERTS = DEF_MAX_EXPERTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // logit_bits[31:0]
    input  logic        s_tlast,   // is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // expert_index[4:0], rank[7:5]
    output logic        m_tlast    // end_of_list
);
    localparam int FW = $clog2(MAX_KEEP+1);

    logic [KEEP_W-1:0] keep_reg;
    logic in_valid_reg, in_last_reg;
    logic [VAL_W-1:0] in_data_reg;
    logic take, rep_load, busy, hold_reg;
    logic [FW-1:0] rep_count;
    logic [MAX_KEEP*IDX_W-1:0] rep_indices;
    logic [IDX_W-1:0] o_idx;
    logic [RANK_W-1:0] o_rank;

    // hold off after a final until its report has drained
    assign s_tready = !busy && !hold_reg;
    assign take = in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= KEEP_RESET;
            in_valid_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                keep_reg <= cfg_wdata;
            in_valid_reg <= s_tvalid && s_tready;
            if (s_tvalid && s_tready && s_tlast)
                hold_reg <= 1'b1;
            else if (rep_load)
                hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= s_tdata;
        in_last_reg <= s_tlast;
    end

    tnls_list #(.MAX_KEEP(MAX_KEEP), .MAX_EXPERTS(MAX_EXPERTS)) u_list (
        .clk(clk), .rst_n(rst_n), .take(take), .value(in_data_reg),
        .last(in_last_reg), .keep_count(keep_reg), .rep_load(rep_load),
        .rep_count(rep_count), .rep_indices(rep_indices)
    );

    tnls_report #(.MAX_KEEP(MAX_KEEP)) u_report (
        .clk(clk), .rst_n(rst_n), .load(rep_load), .count(rep_count),
        .indices(rep_indices), .busy(busy), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_index(o_idx), .out_rank(o_rank), .out_last(m_tlast)
    );

    assign m_tdata = {o_rank, o_idx};
endmodule

// File: design/tnls_list.sv
// Sorted keep list: at most one insertion per accepted item, snapshot on final.
module tnls_list import tnls_pkg::*; #(
    parameter int MAX_KEEP = DEF_MAX_KEEP,
    parameter int MAX_EXPERTS = DEF_MAX_EXPERTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [VAL_W-1:0]              value,
    input  logic                          last,
    input  logic [KEEP_W-1:0]             keep_count,
    output logic                          rep_load,
    output logic [$clog2(MAX_KEEP+1)-1:0] rep_count,
    output logic [MAX_KEEP*IDX_W-1:0]     rep_indices
);
    localparam int FW = $clog2(MAX_KEEP+1);
    localparam int AW = $clog2(MAX_EXPERTS+1);
    localparam int PW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    logic [VAL_W-1:0] val_reg [MAX_KEEP];
    logic [VAL_W-1:0] val_next [MAX_KEEP];
    logic [IDX_W-1:0] idx_reg [MAX_KEEP];
    logic [IDX_W-1:0] idx_next [MAX_KEEP];
    logic [FW-1:0] fill_reg, fill_next, fill_cut, k_eff, start;
    logic [AW-1:0] arr_reg, arr_next;
    logic [MAX_KEEP-1:0] less;
    logic [MAX_KEEP:0] run;
    logic [PW-1:0] last_slot;
    logic ins;

    always_comb
    begin
        if (32'(keep_count) > MAX_KEEP)
            k_eff = FW'(MAX_KEEP);
        else
            k_eff = FW'(keep_count);
        fill_cut = (fill_reg > k_eff) ? k_eff : fill_reg;
        last_slot = PW'(k_eff - 1'b1);
        for (int j = 0; j < MAX_KEEP; j++)
            less[j] = fp_gt(value, val_reg[j]);
        ins = 1'b0;
        start = fill_cut;
        if (32'(arr_reg) < MAX_EXPERTS && k_eff != '0)
        begin
            if (fill_cut < k_eff)
                ins = 1'b1;
            else if (less[last_slot])
            begin
                ins = 1'b1;
                start = k_eff - 1'b1;
            end
        end
        // run[j]: every slot from j up to start is below v, so v may climb to j
        run[MAX_KEEP] = 1'b1;
        for (int j = MAX_KEEP - 1; j >= 0; j--)
            run[j] = (FW'(j) >= start) ? 1'b1 : (less[j] && run[j+1]);
        for (int j = 0; j < MAX_KEEP; j++)
        begin
            val_next[j] = val_reg[j];
            idx_next[j] = idx_reg[j];
            if (ins && FW'(j) <= start)
            begin
                if (j > 0 && run[(j > 0) ? j-1 : 0])
                begin
                    val_next[j] = val_reg[(j > 0) ? j-1 : 0];
                    idx_next[j] = idx_reg[(j > 0) ? j-1 : 0];
                end
                else if (run[j])
                begin
                    val_next[j] = value;
                    idx_next[j] = IDX_W'(arr_reg);
                end
            end
        end
        fill_next = fill_cut;
        arr_next = arr_reg;
        if (32'(arr_reg) < MAX_EXPERTS)
            arr_next = arr_reg + 1'b1;
        if (ins && fill_cut < k_eff)
            fill_next = fill_cut + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            arr_reg <= '0;
            rep_load <= 1'b0;
            rep_count <= '0;
        end
        else
        begin
            rep_load <= take && last;
            if (take)
            begin
                fill_reg <= last ? '0 : fill_next;
                arr_reg <= last ? '0 : arr_next;
                rep_count <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int j = 0; j < MAX_KEEP; j++)
            begin
                val_reg[j] <= val_next[j];
                idx_reg[j] <= idx_next[j];
                rep_indices[j*IDX_W +: IDX_W] <= idx_next[j];
            end
        end
    end
endmodule

// File: design/tnls_report.sv
// Report buffer: walks a snapshot out one entry per beat.
module tnls_report import tnls_pkg::*; #(
    parameter int MAX_KEEP = DEF_MAX_KEEP
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [$clog2(MAX_KEEP+1)-1:0] count,
    input  logic [MAX_KEEP*IDX_W-1:0]     indices,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [IDX_W-1:0]              out_index,
    output logic [RANK_W-1:0]             out_rank,
    output logic                          out_last
);
    localparam int FW = $clog2(MAX_KEEP+1);
    localparam int PW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    logic [MAX_KEEP*IDX_W-1:0] buf_reg;
    logic [FW-1:0] cnt_reg;
    logic [FW-1:0] pos_reg;
    logic [PW-1:0] sel;

    assign sel = pos_reg[PW-1:0];
    assign out_valid = pos_reg < cnt_reg;
    assign busy = out_valid;
    assign out_index = buf_reg[sel*IDX_W +: IDX_W];
    assign out_rank = RANK_W'(pos_reg);
    assign out_last = (pos_reg + 1'b1) == cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= count;
            pos_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= indices;
    end
endmodule

// File: design/tnls_checker.sv
`include "top_n_logit_selector_macros.svh"
module tnls_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    `TNLS_ASSERT(a_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output dropped while stalled")
    `TNLS_ASSERT(a_rank, clk, rst_n, m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tdata[7:5] == $past(m_tdata[7:5]) + 3'd1, "rank not consecutive")
    `TNLS_ASSERT(a_first, clk, rst_n, $rose(m_tvalid) |-> m_tdata[7:5] == 3'd0, "report not starting at rank 0")
    `TNLS_NEVER(a_last_valid, clk, rst_n, m_tlast && !m_tvalid, "end_of_list without valid")
endmodule

bind top_n_logit_selector tnls_checker u_chk (.*);

// File: sim/top_n_logit_selector_test.sv
module top_n_logit_selector_test;
    import tnls_pkg::*;

    localparam int KEEP_MAX = 8;
    localparam int EXPERT_LIMIT = 32;
    localparam int QUIET_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] logit;
        logic        final_flag;
    } logit_req_t;

    typedef struct packed {
        logic [4:0] expert;
        logic [2:0] rank;
        logic       tail;
    } pick_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logit_req_t request_queue[$];
    pick_t      expected_picks[$];

    // shadow of the selector state
    logic [3:0]  keep_reg;
    logic [31:0] list_value[KEEP_MAX];
    logic [4:0]  list_expert[KEEP_MAX];
    int          list_fill;
    int          arrivals;

    bit          failed;
    bit          hold_sender;
    bit          steady_phase;
    bit          req_taken;
    int          quiet_cycles;

    top_n_logit_selector dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    // IEEE greater-than on raw single-precision patterns
    function automatic bit float_above(input logic [31:0] a, input logic [31:0] b);
        bit a_nan;
        bit b_nan;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 0);
        if (a_nan || b_nan) return 0;
        if (a[30:0] == 0 && b[30:0] == 0) return 0;
        if (a[31] != b[31]) return !a[31];
        if (!a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    task automatic insert_logit(input int start, input logic [31:0] v, input int idx);
        int j;
        j = start;
        while (j > 0 && float_above(v, list_value[j-1]))
        begin
            list_value[j] = list_value[j-1];
            list_expert[j] = list_expert[j-1];
            j--;
        end
        list_value[j] = v;
        list_expert[j] = idx[4:0];
    endtask

    task automatic select_top(input logit_req_t r);
        int k;
        pick_t p;
        k = (keep_reg > KEEP_MAX) ? KEEP_MAX : keep_reg;
        if (list_fill > k) list_fill = k;
        if (arrivals < EXPERT_LIMIT)
        begin
            arrivals++;
            if (k > 0)
            begin
                if (list_fill < k)
                begin
                    insert_logit(list_fill, r.logit, arrivals - 1);
                    list_fill++;
                end
                else if (float_above(r.logit, list_value[k-1]))
                    insert_logit(k - 1, r.logit, arrivals - 1);
            end
        end
        if (r.final_flag)
        begin
            for (int i = 0; i < list_fill; i++)
            begin
                p.expert = list_expert[i];
                p.rank = i[2:0];
                p.tail = (i + 1 == list_fill);
                expected_picks.push_back(p);
            end
            list_fill = 0;
            arrivals = 0;
        end
    endtask

    function automatic logic [31:0] random_logit();
        case ($urandom_range(0, 9))
            0: return 32'h7fc00000 | $urandom_range(0, 255);
            1: return $urandom_range(0, 1) ? 32'h80000000 : 32'h00000000;
            2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hff, 23'd0};
            3: return 32'h3f800000 + $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_run(input int len);
        logit_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.logit = random_logit();
            r.final_flag = (i == len - 1);
            request_queue.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || s_tvalid || expected_picks.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_keep(input logic [3:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        keep_reg = v;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !req_taken)
            begin
                // hold the pending request
            end
            else if (request_queue.size() != 0 && !hold_sender
                     && (steady_phase || $urandom_range(0, 99) >= 36))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= request_queue[0].logit;
                s_tlast <= request_queue[0].final_flag;
                void'(request_queue.pop_front());
            end
            else
                s_tvalid <= 1'b0;
            m_tready <= steady_phase || ($urandom_range(0, 99) >= 36);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pick_t got;
        pick_t want;
        req_taken = s_tvalid && s_tready;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (s_tvalid && s_tready)
                select_top('{logit: s_tdata, final_flag: s_tlast});
            if (m_tvalid && m_tready)
            begin
                got = '{expert: m_tdata[4:0], rank: m_tdata[7:5], tail: m_tlast};
                if (expected_picks.size() == 0)
                begin
                    $display("%0t unexpected result expected none actual %h", $time, got);
                    failed = 1;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (got.expert !== want.expert)
                    begin
                        $display("%0t expert_index expected %0d actual %0d",
                                 $time, want.expert, got.expert);
                        failed = 1;
                    end
                    if (got.rank !== want.rank)
                    begin
                        $display("%0t rank expected %0d actual %0d",
                                 $time, want.rank, got.rank);
                        failed = 1;
                    end
                    if (got.tail !== want.tail)
                    begin
                        $display("%0t end_of_list expected %0d actual %0d",
                                 $time, want.tail, got.tail);
                        failed = 1;
                    end
                end
            end
            if (quiet_cycles > QUIET_LIMIT)
            begin
                $display("top_n_logit_selector verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [3:0] keep_plan[6];
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        keep_reg = KEEP_RESET;
        list_fill = 0;
        arrivals = 0;
        failed = 0;
        hold_sender = 0;
        steady_phase = 0;
        quiet_cycles = 0;
        for (int i = 0; i < KEEP_MAX; i++)
        begin
            list_value[i] = 0;
            list_expert[i] = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: reset keep count, extremes, signed zeros, NaN, ties, infinities
        request_queue.push_back('{32'h80000000, 1'b0});
        request_queue.push_back('{32'h00000000, 1'b1});
        request_queue.push_back('{32'h7fc00001, 1'b0});
        request_queue.push_back('{32'h3f800000, 1'b0});
        request_queue.push_back('{32'h3f800000, 1'b1});
        request_queue.push_back('{32'h3f800000, 1'b1});
        request_queue.push_back('{32'hffffffff, 1'b0});
        request_queue.push_back('{32'h7f800000, 1'b0});
        request_queue.push_back('{32'hff800000, 1'b0});
        request_queue.push_back('{32'h00000000, 1'b1});
        wait_drained();
        write_keep(4'd0);
        request_queue.push_back('{32'h3f800000, 1'b0});
        request_queue.push_back('{32'h40000000, 1'b1});
        wait_drained();
        write_keep(4'd15);
        queue_run(40);  // runs past the expert limit
        wait_drained();

        // lower keep count within a run
        write_keep(4'd8);
        queue_run(6);
        void'(request_queue.pop_back());
        wait_drained();
        write_keep(4'd3);
        request_queue.push_back('{32'h00000001, 1'b1});
        wait_drained();

        // random phases over keep settings
        keep_plan = '{4'd1, 4'd8, 4'd5, 4'd12, 4'd2, 4'd7};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_keep(keep_plan[ph]);
            steady_phase = (ph == 3);
            for (int n = 0; n < 6; n++)
                queue_run($urandom_range(0, 5) == 0 ? $urandom_range(28, 36)
                                                    : $urandom_range(1, 10));
            if (ph == 1)
            begin
                while (request_queue.size() > 20)
                    @(posedge clk);
                hold_sender = 1;
                while (expected_picks.size() != 0 || s_tvalid)
                    @(posedge clk);
                hold_sender = 0;
            end
            wait_drained();
        end
        steady_phase = 0;
        repeat (20) @(posedge clk);
        if (!failed)
            $display("top_n_logit_selector verification clean");
        else
            $display("top_n_logit_selector verification failed");
        $finish;
    end
endmodule
